// ===== design/rmq_pkg.sv =====
`timescale 1ns / 1ps
package rmq_pkg;
    localparam int CW        = 16;           // component width
    localparam int FRAC      = CW - 2;       // fraction bits
    localparam int ROW_W     = 3 * CW;       // packed matrix row
    localparam int SUM_W     = CW + 2;       // diagonal sum, signed
    localparam int X_W       = 2 * CW;       // radicand
    localparam int ROOT_W    = CW;           // integer root
    localparam int REM_W     = CW + 2;       // partial remainder
    localparam int PROD_W    = 2 * CW;       // one dot-product term
    localparam int DOT_W     = 2 * CW + 2;   // dot product
    localparam int NLANE     = 4;
    localparam int SQ_STAGES = ROOT_W;       // one root bit per stage

    typedef logic signed [CW-1:0]    comp_t;
    typedef logic signed [SUM_W-1:0] sum_t;
    typedef logic [ROOT_W-1:0]       mag_t;

    // what travels beside the root lanes
    typedef struct packed {
        logic [2:0] neg_xyz;   // sign of x, y, z
        comp_t      nw;
        comp_t      nx;
        comp_t      ny;
        comp_t      nz;
    } side_t;
endpackage

// ===== design/rmq_if.sv =====
`timescale 1ns / 1ps
interface rmq_in_if import rmq_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [ROW_W-1:0]   row_one;
    logic [ROW_W-1:0]   row_two;
    logic [ROW_W-1:0]   row_three;
    logic signed [CW-1:0] near_w;
    logic signed [CW-1:0] near_x;
    logic signed [CW-1:0] near_y;
    logic signed [CW-1:0] near_z;
    modport source (output valid, row_one, row_two, row_three,
                    near_w, near_x, near_y, near_z, input ready);
    modport sink (input valid, row_one, row_two, row_three,
                  near_w, near_x, near_y, near_z, output ready);
endinterface

interface rmq_out_if import rmq_pkg::*; ();
    logic               valid;
    logic               ready;
    logic signed [CW-1:0] quat_w;
    logic signed [CW-1:0] quat_x;
    logic signed [CW-1:0] quat_y;
    logic signed [CW-1:0] quat_z;
    logic               negated;
    modport source (output valid, quat_w, quat_x, quat_y, quat_z, negated,
                    input ready);
    modport sink (input valid, quat_w, quat_x, quat_y, quat_z, negated,
                  output ready);
endinterface

// ===== design/rmq_lane.sv =====
`timescale 1ns / 1ps
module rmq_lane
    import rmq_pkg::*;
(
    input  logic clk,
    input  logic en,
    input  sum_t sum,
    output mag_t mag
);
    logic [REM_W-1:0]  rem_reg  [SQ_STAGES];
    logic [ROOT_W-1:0] root_reg [SQ_STAGES];
    logic [X_W-1:0]    xs_reg   [SQ_STAGES];
    logic [X_W-1:0]    x_in;
    logic [ROOT_W:0]   root_inc;

    // clamp at zero and scale by the fraction
    always_comb
    begin
        if (sum[SUM_W-1] || sum == '0)
            x_in = '0;
        else
            x_in = X_W'(unsigned'(sum)) << FRAC;
    end

    // one root bit per stage
    for (genvar k = 0; k < SQ_STAGES; k++) begin : g_stage
        logic [REM_W-1:0]  rem_i;
        logic [ROOT_W-1:0] root_i;
        logic [X_W-1:0]    xs_i;
        logic [REM_W+1:0]  rem_sh;
        logic [REM_W+1:0]  trial;
        logic              ge;

        always_comb
        begin
            if (k == 0)
            begin
                rem_i  = '0;
                root_i = '0;
                xs_i   = x_in;
            end
            else
            begin
                rem_i  = rem_reg[(k == 0) ? 0 : k-1];
                root_i = root_reg[(k == 0) ? 0 : k-1];
                xs_i   = xs_reg[(k == 0) ? 0 : k-1];
            end
            rem_sh = {rem_i, xs_i[X_W-1 -: 2]};
            trial  = (REM_W+2)'({root_i, 2'b01});
            ge     = (rem_sh >= trial);
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= ge ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
                root_reg[k] <= {root_i[ROOT_W-2:0], ge};
                xs_reg[k]   <= xs_i << 2;
            end
        end
    end

    // round half up
    assign root_inc = {1'b0, root_reg[SQ_STAGES-1]} + (ROOT_W+1)'(1);
    assign mag      = root_inc[ROOT_W:1];
endmodule

// ===== design/rmq_merge.sv =====
`timescale 1ns / 1ps
module rmq_merge
    import rmq_pkg::*;
(
    input  logic  clk,
    input  logic  en,
    input  mag_t  mag [NLANE],
    input  side_t side,
    output comp_t q_out [NLANE],
    output logic  neg_out
);
    comp_t               q_c    [NLANE];
    comp_t               n_c    [NLANE];
    comp_t               q_reg  [NLANE];
    logic signed [PROD_W-1:0] prod_reg [NLANE];
    comp_t               q_next [NLANE];
    logic signed [DOT_W-1:0]  dot;
    logic                neg_reg;
    comp_t               qo_reg [NLANE];

    // apply the off-diagonal signs
    always_comb
    begin
        q_c[0] = comp_t'(mag[0]);
        for (int i = 1; i < NLANE; i++)
            q_c[i] = side.neg_xyz[i-1] ? -comp_t'(mag[i]) : comp_t'(mag[i]);
        n_c[0] = side.nw;
        n_c[1] = side.nx;
        n_c[2] = side.ny;
        n_c[3] = side.nz;
    end

    // register the products
    always_ff @(posedge clk)
    begin
        if (en)
            for (int i = 0; i < NLANE; i++)
            begin
                q_reg[i]    <= q_c[i];
                prod_reg[i] <= n_c[i] * q_c[i];
            end
    end

    // sum, decide and negate
    always_comb
    begin
        dot = '0;
        for (int i = 0; i < NLANE; i++)
            dot = dot + DOT_W'(prod_reg[i]);
        for (int i = 0; i < NLANE; i++)
            q_next[i] = dot[DOT_W-1] ? -q_reg[i] : q_reg[i];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            qo_reg  <= q_next;
            neg_reg <= dot[DOT_W-1];
        end
    end

    assign q_out   = qo_reg;
    assign neg_out = neg_reg;
endmodule

// ===== design/rotation_matrix_to_quaternion_nearest.sv =====
`timescale 1ns / 1ps
// channel | dir | fields
// in_ch   | in  | row_one, row_two, row_three, near_w..near_z
// out_ch  | out | quat_w..quat_z, negated
//
// One item per cycle while the output is not stalled: sum stage, 16 root stages
// (one root bit each in four lanes), product stage, output register.
// The whole pipeline advances when the output register is empty or taken.
// Reset clears only the valid bits.
module rotation_matrix_to_quaternion_nearest
    import rmq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    rmq_in_if.sink      in_ch,
    rmq_out_if.source   out_ch
);
    localparam int DEPTH = SQ_STAGES + 3;

    logic  [DEPTH-1:0] v_reg;
    logic              adv;
    comp_t             e [9];
    sum_t              sum_reg [NLANE];
    side_t             side_reg [SQ_STAGES+1];
    side_t             side_in;
    mag_t              mag [NLANE];
    comp_t             q [NLANE];
    logic              neg;
    logic signed [CW:0] d32, d13, d21;

    assign adv         = !v_reg[DEPTH-1] || out_ch.ready;
    assign in_ch.ready = adv;

    // unpack the matrix
    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            e[j]   = comp_t'(in_ch.row_one[j*CW +: CW]);
            e[3+j] = comp_t'(in_ch.row_two[j*CW +: CW]);
            e[6+j] = comp_t'(in_ch.row_three[j*CW +: CW]);
        end
        d32 = (CW+1)'(e[7]) - (CW+1)'(e[5]);
        d13 = (CW+1)'(e[2]) - (CW+1)'(e[6]);
        d21 = (CW+1)'(e[3]) - (CW+1)'(e[1]);
        side_in.neg_xyz = {d21[CW], d13[CW], d32[CW]};
        side_in.nw = in_ch.near_w;
        side_in.nx = in_ch.near_x;
        side_in.ny = in_ch.near_y;
        side_in.nz = in_ch.near_z;
    end

    // diagonal sums and sideband delay line
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sum_reg[0] <= (SUM_W'(1) <<< FRAC) + SUM_W'(e[0]) + SUM_W'(e[4]) + SUM_W'(e[8]);
            sum_reg[1] <= (SUM_W'(1) <<< FRAC) + SUM_W'(e[0]) - SUM_W'(e[4]) - SUM_W'(e[8]);
            sum_reg[2] <= (SUM_W'(1) <<< FRAC) - SUM_W'(e[0]) + SUM_W'(e[4]) - SUM_W'(e[8]);
            sum_reg[3] <= (SUM_W'(1) <<< FRAC) - SUM_W'(e[0]) - SUM_W'(e[4]) + SUM_W'(e[8]);
            side_reg[0] <= side_in;
            for (int k = 1; k <= SQ_STAGES; k++)
                side_reg[k] <= side_reg[k-1];
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (adv)
            v_reg <= {v_reg[DEPTH-2:0], in_ch.valid};
    end

    for (genvar l = 0; l < NLANE; l++) begin : g_lane
        rmq_lane u_lane (
            .clk (clk),
            .en  (adv),
            .sum (sum_reg[l]),
            .mag (mag[l])
        );
    end

    rmq_merge u_merge (
        .clk     (clk),
        .en      (adv),
        .mag     (mag),
        .side    (side_reg[SQ_STAGES]),
        .q_out   (q),
        .neg_out (neg)
    );

    assign out_ch.valid   = v_reg[DEPTH-1];
    assign out_ch.quat_w  = q[0];
    assign out_ch.quat_x  = q[1];
    assign out_ch.quat_y  = q[2];
    assign out_ch.quat_z  = q[3];
    assign out_ch.negated = neg;

    // w is never negative unless the item was negated
    a_w_sign: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.negated |-> !out_ch.quat_w[CW-1])
        else $error("w negative without negation");

    // an accepted item enters the first stage
    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.valid && in_ch.ready |=> v_reg[0])
        else $error("accepted item lost");

    // a stalled output blocks the input
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |-> !in_ch.ready)
        else $error("input taken during stall");
endmodule

// ===== tb/tb_rotation_matrix_to_quaternion_nearest.sv =====
`timescale 1ns / 1ps
module tb_rotation_matrix_to_quaternion_nearest;
    import rmq_pkg::*;

    typedef struct {
        logic [ROW_W-1:0] r1;
        logic [ROW_W-1:0] r2;
        logic [ROW_W-1:0] r3;
        comp_t            nw;
        comp_t            nx;
        comp_t            ny;
        comp_t            nz;
    } pose_t;

    typedef struct {
        comp_t w;
        comp_t x;
        comp_t y;
        comp_t z;
        logic  neg;
    } quat_t;

    typedef struct {
        pose_t p;
        bit    typed;
        quat_t q;
    } row_t;

    localparam int LATENCY   = 19;
    localparam int MAX_CYCLES = 400000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   cycle = 0;
    int   errors = 0;
    int   send_idle = 0;
    int   recv_stall = 0;
    quat_t quat_fifo[$];

    rmq_in_if  in_ch ();
    rmq_out_if out_ch ();

    rotation_matrix_to_quaternion_nearest dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    always #5 clk = ~clk;

    // half root of a diagonal sum, rounded to nearest
    function automatic longint half_root(longint s);
        longint unsigned x;
        longint unsigned r;
        longint unsigned b;
        if (s <= 0)
            return 0;
        x = longint'(s) << FRAC;
        r = 0;
        b = 64'd1 << 62;
        while (b > x)
            b >>= 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return longint'((r + 1) >> 1);
    endfunction

    function automatic longint ent(logic [ROW_W-1:0] row, int col);
        comp_t v;
        v = row[col*CW +: CW];
        return longint'(v);
    endfunction

    // expected quaternion for one pose
    function automatic quat_t to_quat(pose_t p);
        longint one;
        longint m[3][3];
        longint q[4];
        longint n[4];
        longint dot;
        quat_t  o;
        one = longint'(1) << FRAC;
        for (int c = 0; c < 3; c++)
        begin
            m[0][c] = ent(p.r1, c);
            m[1][c] = ent(p.r2, c);
            m[2][c] = ent(p.r3, c);
        end
        q[0] = half_root(one + m[0][0] + m[1][1] + m[2][2]);
        q[1] = half_root(one + m[0][0] - m[1][1] - m[2][2]);
        q[2] = half_root(one - m[0][0] + m[1][1] - m[2][2]);
        q[3] = half_root(one - m[0][0] - m[1][1] + m[2][2]);
        if (m[2][1] - m[1][2] < 0) q[1] = -q[1];
        if (m[0][2] - m[2][0] < 0) q[2] = -q[2];
        if (m[1][0] - m[0][1] < 0) q[3] = -q[3];
        n[0] = p.nw; n[1] = p.nx; n[2] = p.ny; n[3] = p.nz;
        dot = 0;
        for (int i = 0; i < 4; i++)
            dot += n[i] * q[i];
        o.neg = dot < 0;
        if (o.neg)
            for (int i = 0; i < 4; i++)
                q[i] = -q[i];
        o.w = q[0][CW-1:0];
        o.x = q[1][CW-1:0];
        o.y = q[2][CW-1:0];
        o.z = q[3][CW-1:0];
        return o;
    endfunction

    function automatic logic [ROW_W-1:0] pack3(comp_t a, comp_t b, comp_t c);
        return {c, b, a};
    endfunction

    function automatic comp_t rnd_comp();
        case ($urandom_range(0, 3))
            0: return comp_t'($urandom);
            1: return comp_t'($urandom_range(0, 1) ? 16'h4000 : 16'hC000);
            2: return comp_t'($urandom_range(0, 1) ? 16'h7FFF : 16'h8000);
            default: return comp_t'(int'($urandom_range(0, 32768)) - 16384);
        endcase
    endfunction

    function automatic pose_t rnd_pose();
        pose_t p;
        int    k;
        comp_t a;
        k = $urandom_range(0, 9);
        if (k < 6)
        begin
            // near-rotation: one skew off-diagonal pair, the other entries random
            a = comp_t'($urandom_range(0, 8000));
            p.r1 = pack3(comp_t'($urandom_range(0, 16384)), a, comp_t'($urandom));
            p.r2 = pack3(-a, comp_t'(int'($urandom_range(0, 32768)) - 16384),
                         comp_t'($urandom_range(0, 16384)));
            p.r3 = pack3(comp_t'($urandom_range(0, 4000)), comp_t'($urandom),
                         comp_t'(int'($urandom_range(0, 32768)) - 16384));
        end
        else
        begin
            p.r1 = pack3(rnd_comp(), rnd_comp(), rnd_comp());
            p.r2 = pack3(rnd_comp(), rnd_comp(), rnd_comp());
            p.r3 = pack3(rnd_comp(), rnd_comp(), rnd_comp());
        end
        p.nw = rnd_comp();
        p.nx = rnd_comp();
        p.ny = rnd_comp();
        p.nz = rnd_comp();
        if ($urandom_range(0, 15) == 0)
        begin
            p.nw = 0; p.nx = 0; p.ny = 0; p.nz = 0;
        end
        return p;
    endfunction

    // hold one item on the input until taken
    task automatic send(pose_t p);
        while (send_idle > 0 && $urandom_range(0, 99) < send_idle)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.row_one   <= p.r1;
        in_ch.row_two   <= p.r2;
        in_ch.row_three <= p.r3;
        in_ch.near_w    <= p.nw;
        in_ch.near_x    <= p.nx;
        in_ch.near_y    <= p.ny;
        in_ch.near_z    <= p.nz;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        quat_fifo.push_back(to_quat(p));
    endtask

    // drive receiver ready
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
            out_ch.ready <= ($urandom_range(0, 99) >= recv_stall);
    end

    // compare every taken result with the oldest expectation
    always @(posedge clk)
    begin
        quat_t e;
        cycle <= cycle + 1;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (quat_fifo.size() == 0)
            begin
                $display("%0t: result with nothing expected: %h %h %h %h %b", $time,
                         out_ch.quat_w, out_ch.quat_x, out_ch.quat_y, out_ch.quat_z,
                         out_ch.negated);
                errors++;
            end
            else
            begin
                e = quat_fifo.pop_front();
                if (out_ch.quat_w !== e.w || out_ch.quat_x !== e.x ||
                    out_ch.quat_y !== e.y || out_ch.quat_z !== e.z ||
                    out_ch.negated !== e.neg)
                begin
                    $display("%0t: expected %h %h %h %h %b, got %h %h %h %h %b", $time,
                             e.w, e.x, e.y, e.z, e.neg, out_ch.quat_w, out_ch.quat_x,
                             out_ch.quat_y, out_ch.quat_z, out_ch.negated);
                    errors++;
                end
            end
        end
        if (cycle >= MAX_CYCLES)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic row_t mk(pose_t p, bit typed, quat_t q);
        row_t r;
        r.p = p; r.typed = typed; r.q = q;
        return r;
    endfunction

    function automatic pose_t pz(logic [ROW_W-1:0] a, logic [ROW_W-1:0] b,
                                 logic [ROW_W-1:0] c, comp_t w, comp_t x,
                                 comp_t y, comp_t z);
        pose_t p;
        p.r1 = a; p.r2 = b; p.r3 = c;
        p.nw = w; p.nx = x; p.ny = y; p.nz = z;
        return p;
    endfunction

    initial
    begin
        row_t  stim[$];
        quat_t q;
        quat_t none;
        logic [ROW_W-1:0] id1;
        logic [ROW_W-1:0] id2;
        logic [ROW_W-1:0] id3;
        int    phase;

        in_ch.valid     <= 1'b0;
        in_ch.row_one   <= '0;
        in_ch.row_two   <= '0;
        in_ch.row_three <= '0;
        in_ch.near_w    <= '0;
        in_ch.near_x    <= '0;
        in_ch.near_y    <= '0;
        in_ch.near_z    <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        none = '{0, 0, 0, 0, 1'b0};
        id1 = pack3(16'sh4000, 0, 0);
        id2 = pack3(0, 16'sh4000, 0);
        id3 = pack3(0, 0, 16'sh4000);

        // identity with positive, negative and zero neighbours
        q = '{16'sh4000, 0, 0, 0, 1'b0};
        stim.push_back(mk(pz(id1, id2, id3, 16'sh4000, 0, 0, 0), 1, q));
        q = '{-16'sh4000, 0, 0, 0, 1'b1};
        stim.push_back(mk(pz(id1, id2, id3, -16'sh4000, 0, 0, 0), 1, q));
        q = '{16'sh4000, 0, 0, 0, 1'b0};
        stim.push_back(mk(pz(id1, id2, id3, 0, 0, 0, 0), 1, q));
        // orthogonal neighbour is a tie
        stim.push_back(mk(pz(id1, id2, id3, 0, 16'sh7FFF, 16'sh8000, 0), 1, q));
        // all-zero matrix: every sum is one
        q = '{16'sh2000, 16'sh2000, 16'sh2000, 16'sh2000, 1'b0};
        stim.push_back(mk(pz(0, 0, 0, 0, 0, 0, 0), 1, q));
        // all-ones pattern, all-max, all-min, negative diagonal clamps
        stim.push_back(mk(pz('1, '1, '1, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
                             16'sh7FFF), 0, none));
        stim.push_back(mk(pz({3{16'h7FFF}}, {3{16'h7FFF}}, {3{16'h7FFF}},
                             16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000), 0, none));
        stim.push_back(mk(pz({3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}},
                             16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000), 0, none));
        stim.push_back(mk(pz(pack3(16'sh8000, 0, 0), pack3(0, 16'sh8000, 0),
                             pack3(0, 0, 16'sh8000), 1, -1, 1, -1), 0, none));
        // a half-turn about x, quarter-turns about z, y and x, and skew signs both ways
        stim.push_back(mk(pz(id1, pack3(0, 16'shC000, 0), pack3(0, 0, 16'shC000),
                             0, -16'sh4000, 0, 0), 0, none));
        stim.push_back(mk(pz(pack3(0, 16'shC000, 0), pack3(16'sh4000, 0, 0), id3,
                             16'sh1000, 0, 0, -16'sh2000), 0, none));
        stim.push_back(mk(pz(pack3(0, 0, 16'sh4000), id2, pack3(16'shC000, 0, 0),
                             0, 0, 16'sh8000, 0), 0, none));
        stim.push_back(mk(pz(id1, pack3(0, 0, 16'sh4000), pack3(0, 16'shC000, 0),
                             -1, -1, -1, -1), 0, none));

        foreach (stim[i])
        begin
            send(stim[i].p);
            if (stim[i].typed)
                quat_fifo[quat_fifo.size()-1] = stim[i].q;
        end

        // random items over the idling phases
        for (phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 72; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 72; end
                3: begin send_idle = 32; recv_stall = 32; end
                default: begin send_idle = 0; recv_stall = 0; end
            endcase
            repeat (390)
                send(rnd_pose());
        end
        in_ch.valid <= 1'b0;

        while (quat_fifo.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

// ===== rotation_matrix_to_quaternion_nearest.f =====
design/rmq_pkg.sv
design/rmq_if.sv
design/rmq_lane.sv
design/rmq_merge.sv
design/rotation_matrix_to_quaternion_nearest.sv
tb/tb_rotation_matrix_to_quaternion_nearest.sv
